// File: rtl/x86cbu_pkg.sv
// ----------------------------------------------------------------------------
// x86cbu_pkg
// shared types and constants of the x86 call/jump branch unfilter
// ----------------------------------------------------------------------------
package x86cbu_pkg;

    // opcodes that carry a 32-bit relative operand
    localparam logic [7:0]  OPC_CALL   = 8'hE8;
    localparam logic [7:0]  OPC_JMP    = 8'hE9;

    // operand high byte values that mark a converted address
    localparam logic [7:0]  HI_ZERO    = 8'h00;
    localparam logic [7:0]  HI_ONES    = 8'hFF;

    // hold counter: idle, and opcode plus three operand bytes held
    localparam logic [2:0]  HOLD_IDLE  = 3'd0;
    localparam logic [2:0]  HOLD_FULL  = 3'd4;

    // opcode plus operand length in bytes
    localparam logic [23:0] INSN_LEN   = 24'd5;

    // bytes a single input can release
    localparam int          GROUP_MAX  = 4;

    // group of result bytes released by one input transfer
    typedef struct packed {
        logic [GROUP_MAX-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      bend;
    } t_group;

endpackage

// File: rtl/x86_call_branch_unfilter.sv
// ----------------------------------------------------------------------------
// x86_call_branch_unfilter
// restores x86 call/jump operands in a block-structured byte stream
// ----------------------------------------------------------------------------
// One input byte is taken per cycle unless the input is stalled, and its
// results (none, one or up to four bytes) are computed in that same cycle into
// a group register, which then sets the rate: one result byte per cycle while
// the output is not stalled. A held operand byte yields nothing, a plain byte
// yields one, and a completed operand or a flush yields up to four, so after
// such a byte the input is stalled until its last result byte leaves.
// ----------------------------------------------------------------------------
module x86_call_branch_unfilter
    import x86cbu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_file_start,
    input  logic       i_block_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_out_block_end
);

    logic   ready;
    logic   take;
    t_group group;

    // input transfer
    assign o_stall = !ready;
    assign take    = i_valid && ready;

    x86cbu_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_in_byte    (i_in_byte),
        .i_file_start (i_file_start),
        .i_block_end  (i_block_end),
        .o_group      (group)
    );

    x86cbu_outbuf u_outbuf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (take && (group.cnt != 3'd0)),
        .i_group         (group),
        .o_ready         (ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_out_block_end (o_out_block_end)
    );

endmodule

// File: rtl/x86cbu_core.sv
// ----------------------------------------------------------------------------
// x86cbu_core
// opcode scan, operand hold and address conversion for one byte per cycle while i_take is set
// ----------------------------------------------------------------------------
module x86cbu_core
    import x86cbu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_in_byte,
    input  logic       i_file_start,
    input  logic       i_block_end,
    output t_group     o_group
);

    logic [23:0] r_pos, n_pos;
    logic [2:0]  r_hold, n_hold;
    logic [7:0]  r_held [3];
    logic [23:0] r_opos5, n_opos5;

    logic [23:0] pos;
    logic [2:0]  hold_eff;
    logic [2:0]  flush_cnt;
    logic        is_opc;
    logic [23:0] lo_raw, lo_cvt;
    logic [7:0]  hi_cvt;
    logic        do_cvt;
    t_group      grp;

    // position of the current byte, restarted at file start
    assign pos      = i_file_start ? 24'd0 : r_pos;
    assign hold_eff = i_file_start ? HOLD_IDLE : r_hold;
    assign is_opc   = (i_in_byte == OPC_CALL) || (i_in_byte == OPC_JMP);

    // operand conversion, relative address restored
    assign lo_raw = {r_held[2], r_held[1], r_held[0]};
    assign do_cvt = (i_in_byte == HI_ZERO) || (i_in_byte == HI_ONES);
    always_comb begin
        lo_cvt = lo_raw;
        hi_cvt = i_in_byte;
        if (do_cvt) begin
            lo_cvt = lo_raw - r_opos5;
            if (lo_cvt[23]) begin
                hi_cvt = ~i_in_byte;
            end
        end
    end

    // number of held bytes flushed ahead of the current byte
    always_comb begin
        flush_cnt = 3'd0;
        if (i_file_start && (r_hold != HOLD_IDLE)) begin
            flush_cnt = r_hold - 3'd1;
        end else if (!i_file_start && (r_hold != HOLD_IDLE) && (r_hold != HOLD_FULL)
                     && i_block_end) begin
            flush_cnt = r_hold - 3'd1;
        end
    end

    // result group and next hold state
    always_comb begin
        grp      = '0;
        grp.bend = i_block_end;
        n_hold   = r_hold;
        n_opos5  = r_opos5;
        if (hold_eff == HOLD_FULL) begin
            grp.bytes[0] = lo_cvt[7:0];
            grp.bytes[1] = lo_cvt[15:8];
            grp.bytes[2] = lo_cvt[23:16];
            grp.bytes[3] = hi_cvt;
            grp.cnt      = 3'd4;
            n_hold       = HOLD_IDLE;
        end else if ((hold_eff != HOLD_IDLE) && !i_block_end) begin
            // operand byte only held
            grp.cnt = 3'd0;
            n_hold  = r_hold + 3'd1;
        end else begin
            // held prefix then the current byte
            for (int i = 0; i < GROUP_MAX; i++) begin
                if ((i < 3) && (3'(i) < flush_cnt)) begin
                    grp.bytes[i] = r_held[i];
                end else if (3'(i) == flush_cnt) begin
                    grp.bytes[i] = i_in_byte;
                end
            end
            grp.cnt = flush_cnt + 3'd1;
            n_hold  = HOLD_IDLE;
            if ((hold_eff == HOLD_IDLE) && !i_block_end && is_opc) begin
                n_hold  = 3'd1;
                n_opos5 = pos + INSN_LEN;
            end
        end
    end

    assign n_pos   = pos + 24'd1;
    assign o_group = grp;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hold  <= HOLD_IDLE;
            r_opos5 <= INSN_LEN;
        end else if (i_take) begin
            r_pos   <= n_pos;
            r_hold  <= n_hold;
            r_opos5 <= n_opos5;
        end
    end

    // operand byte store
    always_ff @(posedge i_clk) begin
        if (i_take && !i_file_start && (r_hold != HOLD_IDLE) && (r_hold != HOLD_FULL)
            && !i_block_end) begin
            r_held[r_hold[1:0] - 2'd1] <= i_in_byte;
        end
    end

endmodule

// File: rtl/x86cbu_outbuf.sv
// ----------------------------------------------------------------------------
// x86cbu_outbuf
// result group register, releases one byte per output transfer
// ----------------------------------------------------------------------------
module x86cbu_outbuf
    import x86cbu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_group     i_group,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_out_block_end
);

    logic                      r_valid;
    logic [GROUP_MAX-1:0][7:0] r_bytes;
    logic [2:0]                r_cnt;
    logic [1:0]                r_idx;
    logic                      r_bend;

    logic last;
    logic xfer;

    assign last = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign xfer = r_valid && !i_stall;

    // free when empty or the final byte leaves this cycle
    assign o_ready = !r_valid || (xfer && last);

    assign o_valid         = r_valid;
    assign o_out_byte      = r_bytes[r_idx];
    assign o_run_last      = last;
    assign o_out_block_end = last && r_bend;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (xfer) begin
            if (last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_group.bytes;
            r_cnt   <= i_group.cnt;
            r_bend  <= i_group.bend;
        end
    end

endmodule
